FILE: hw/rtl/stid_pkg.sv
// shared types, sizes and codes for the sorted table block
package stid_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int POS_W       = 7;
    localparam int STATUS_W    = 2;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed
    {
        logic                          kind;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [POS_W-1:0]              position;
    } stid_req_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0]           status;
        logic [POS_W-1:0]              where;
        logic signed [VALUE_WIDTH-1:0] removed_value;
        logic [POS_W-1:0]              entry_count;
    } stid_rsp_t;

    // command broadcast to every cell of the chain
    typedef struct packed
    {
        logic                          ins_en;
        logic                          del_en;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]              position;
        logic [CNT_W-1:0]              count;
    } stid_cmd_t;

endpackage

FILE: hw/rtl/sorted_table_insert_delete_top.sv
// top level of the sorted table with insert and delete
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | in_data  (kind, value, position)
//  out     | out_valid / out_ready | out_data (status, where, removed_value,
//          |                       |           entry_count)
//
// one request per cycle: the whole chain compares against the broadcast value
// or position and shifts in the same edge that accepts the request
// the result is loaded into the output register on the edge that accepts the request
// reset clears the count and the output valid; entry cells are not reset
// a stalled output holds in_ready low only while its register is full and
// not being taken
module sorted_table_insert_delete_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  stid_pkg::stid_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output stid_pkg::stid_rsp_t out_data
);

    logic [stid_pkg::CNT_W-1:0]              count_reg;
    logic [stid_pkg::CNT_W-1:0]              count_next;
    logic                                    out_valid_reg;
    stid_pkg::stid_rsp_t                     out_data_reg;
    stid_pkg::stid_rsp_t                     out_data_next;

    logic                                    accept;
    logic                                    is_delete;
    logic                                    full;
    logic                                    pos_ok;
    logic                                    ins_ok;
    logic                                    del_ok;
    logic [stid_pkg::CNT_W-1:0]              pos_ext;
    stid_pkg::stid_cmd_t                     cmd;
    logic [stid_pkg::CNT_W-1:0]              ins_where;
    logic signed [stid_pkg::VALUE_WIDTH-1:0] hit_value;

    // output register frees up when taken, so a new request can enter then
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_delete = in_data.kind == stid_pkg::OP_DELETE;
    assign full      = count_reg == stid_pkg::CNT_W'(stid_pkg::DEPTH);
    assign pos_ext   = stid_pkg::CNT_W'(in_data.position);
    // one-based position must land on an occupied entry
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_reg);
    assign ins_ok    = !is_delete && !full;
    assign del_ok    = is_delete && pos_ok;

    // broadcast to the cells; enables gate the shift to accepted requests
    always_comb
    begin
        cmd.ins_en   = accept && ins_ok;
        cmd.del_en   = accept && del_ok;
        cmd.value    = in_data.value;
        cmd.position = pos_ext;
        cmd.count    = count_reg;
    end

    stid_chain u_chain
    (
        .clk       (clk),
        .cmd       (cmd),
        .ins_where (ins_where),
        .hit_value (hit_value)
    );

    // result of the request presented this cycle
    always_comb
    begin
        count_next                  = count_reg;
        out_data_next.status        = stid_pkg::ST_DONE;
        out_data_next.where         = '0;
        out_data_next.removed_value = '0;
        if (ins_ok)
        begin
            count_next          = count_reg + stid_pkg::CNT_W'(1);
            out_data_next.where = stid_pkg::POS_W'(ins_where);
        end
        else if (del_ok)
        begin
            count_next                  = count_reg - stid_pkg::CNT_W'(1);
            out_data_next.where         = in_data.position;
            out_data_next.removed_value = hit_value;
        end
        else if (is_delete)
        begin
            out_data_next.status = stid_pkg::ST_BAD_POS;
        end
        else
        begin
            out_data_next.status = stid_pkg::ST_FULL;
        end
        out_data_next.entry_count = stid_pkg::POS_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, loaded only with a request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: hw/rtl/stid_cell.sv
// one storage cell of the sorted chain
module stid_cell
(
    input  logic                                  clk,
    input  stid_pkg::stid_cmd_t                   cmd,
    input  logic [stid_pkg::IDX_W-1:0]            cell_idx,
    input  logic signed [stid_pkg::VALUE_WIDTH-1:0] left_entry,
    input  logic                                  left_lt,
    input  logic signed [stid_pkg::VALUE_WIDTH-1:0] right_entry,
    output logic signed [stid_pkg::VALUE_WIDTH-1:0] entry,
    output logic                                  lt,
    output logic                                  ins_point,
    output logic                                  hit
);

    logic signed [stid_pkg::VALUE_WIDTH-1:0] entry_reg;
    logic [stid_pkg::CNT_W-1:0]              idx_ext;
    logic [stid_pkg::CNT_W-1:0]              idx_p1;
    logic                                    occupied;
    logic                                    ge_pos;

    assign idx_ext   = stid_pkg::CNT_W'(cell_idx);
    assign idx_p1    = idx_ext + stid_pkg::CNT_W'(1);
    assign occupied  = idx_ext < cmd.count;
    // ascending order: lt flags form a prefix of the occupied cells
    assign lt        = occupied && (entry_reg < cmd.value);
    assign ins_point = !lt && left_lt;
    assign ge_pos    = idx_p1 >= cmd.position;
    assign hit       = idx_p1 == cmd.position;
    assign entry     = entry_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ins_en && !lt)
        begin
            entry_reg <= left_lt ? cmd.value : left_entry;
        end
        else if (cmd.del_en && ge_pos)
        begin
            entry_reg <= right_entry;
        end
    end

endmodule

FILE: hw/rtl/stid_chain.sv
// row of cells with insert point and removed value collection
module stid_chain
(
    input  logic                                    clk,
    input  stid_pkg::stid_cmd_t                     cmd,
    output logic [stid_pkg::CNT_W-1:0]              ins_where,
    output logic signed [stid_pkg::VALUE_WIDTH-1:0] hit_value
);

    logic signed [stid_pkg::VALUE_WIDTH-1:0] entries [stid_pkg::DEPTH];
    logic [stid_pkg::DEPTH-1:0]              lt_vec;
    logic [stid_pkg::DEPTH-1:0]              ins_vec;
    logic [stid_pkg::DEPTH-1:0]              hit_vec;

    for (genvar i = 0; i < stid_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [stid_pkg::VALUE_WIDTH-1:0] left_entry;
        logic signed [stid_pkg::VALUE_WIDTH-1:0] right_entry;
        logic                                    left_lt;

        if (i == 0)
        begin : g_first
            assign left_entry = cmd.value;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign left_entry = entries[i-1];
            assign left_lt    = lt_vec[i-1];
        end

        if (i == stid_pkg::DEPTH - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        stid_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .cell_idx    (stid_pkg::IDX_W'(i)),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .lt          (lt_vec[i]),
            .ins_point   (ins_vec[i]),
            .hit         (hit_vec[i])
        );
    end

    // at most one cell flags each, so an or over the row selects it
    always_comb
    begin
        ins_where = '0;
        hit_value = '0;
        for (int i = 0; i < stid_pkg::DEPTH; i++)
        begin
            if (ins_vec[i])
            begin
                ins_where = ins_where | stid_pkg::CNT_W'(i + 1);
            end
            if (hit_vec[i])
            begin
                hit_value = hit_value | entries[i];
            end
        end
    end

endmodule

FILE: hw/rtl/stid_checker.sv
// port level checks for the sorted table, bound to the top level
module stid_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input stid_pkg::stid_rsp_t out_data
);

    // every accepted request shows a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after accepted request");

    // a failed request reports no position and no removed value
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != stid_pkg::ST_DONE)) |->
        ((out_data.where == '0) && (out_data.removed_value == '0)))
        else $error("error result carries data");

    // a full report only comes with a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == stid_pkg::ST_FULL)) |->
        (out_data.entry_count == stid_pkg::POS_W'(stid_pkg::DEPTH)))
        else $error("full status with table not full");

    // a successful position is nonzero and at most one past the entry count after the change
    a_where_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == stid_pkg::ST_DONE)) |->
        ((out_data.where != '0) &&
         (out_data.where <= out_data.entry_count + stid_pkg::POS_W'(1))))
        else $error("position out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind sorted_table_insert_delete_top stid_checker u_stid_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
